// ===== rtl/core/msc_pkg.sv =====
// Shared types, codes and the frame length table of the MP3 frame scanner.
// Used by the controller, the datapath, the top level and the checker.
package msc_pkg;

  localparam int OFFSET_BITS = 32;

  // result status codes
  localparam logic [1:0] STAT_FRAME   = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_EOF     = 2'd2;

  localparam logic [23:0] MARK_ID3V1 = 24'h544147;  // "TAG"
  localparam logic [23:0] MARK_ID3V2 = 24'h494433;  // "ID3"
  localparam logic [27:0] ID3V1_REST = 28'd125;
  localparam logic [3:0]  ID3V2_HDR_BYTES = 4'd10;
  localparam logic [3:0]  ID3V2_SIZE_START = 4'd7;

  typedef enum logic [1:0] {
    MODE_BOUNDARY,
    MODE_ID3,
    MODE_SKIP,
    MODE_STOPPED
  } msc_mode_t;

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_RES,
    ST_RES_THEN_EOF
  } msc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic step;      // consume the input byte
    logic load_eof;  // turn the held result into the end-of-file result
  } msc_cmd_t;

  // datapath -> controller, valid alongside the presented byte
  typedef struct packed {
    logic res_any;   // this byte yields at least one result
    logic eof_next;  // an end-of-file result follows the first one
  } msc_sts_t;

  function automatic logic [15:0] rate_hz(input logic [1:0] fi);
    logic [15:0] r;
    unique case (fi)
      2'd0:    r = 16'd44100;
      2'd1:    r = 16'd48000;
      default: r = 16'd32000;
    endcase
    return r;
  endfunction

  // floor(144 * kbps * 1000 / rate), padding excluded
  function automatic logic [10:0] frame_len(input logic [3:0] br, input logic [1:0] fi);
    logic [10:0] l44, l48, l32;
    unique case (br)
      4'd1:    begin l44 = 11'd104;  l48 = 11'd96;  l32 = 11'd144;  end
      4'd2:    begin l44 = 11'd130;  l48 = 11'd120; l32 = 11'd180;  end
      4'd3:    begin l44 = 11'd156;  l48 = 11'd144; l32 = 11'd216;  end
      4'd4:    begin l44 = 11'd182;  l48 = 11'd168; l32 = 11'd252;  end
      4'd5:    begin l44 = 11'd208;  l48 = 11'd192; l32 = 11'd288;  end
      4'd6:    begin l44 = 11'd261;  l48 = 11'd240; l32 = 11'd360;  end
      4'd7:    begin l44 = 11'd313;  l48 = 11'd288; l32 = 11'd432;  end
      4'd8:    begin l44 = 11'd365;  l48 = 11'd336; l32 = 11'd504;  end
      4'd9:    begin l44 = 11'd417;  l48 = 11'd384; l32 = 11'd576;  end
      4'd10:   begin l44 = 11'd522;  l48 = 11'd480; l32 = 11'd720;  end
      4'd11:   begin l44 = 11'd626;  l48 = 11'd576; l32 = 11'd864;  end
      4'd12:   begin l44 = 11'd731;  l48 = 11'd672; l32 = 11'd1008; end
      4'd13:   begin l44 = 11'd835;  l48 = 11'd768; l32 = 11'd1152; end
      4'd14:   begin l44 = 11'd1044; l48 = 11'd960; l32 = 11'd1440; end
      default: begin l44 = 11'd0;    l48 = 11'd0;   l32 = 11'd0;    end
    endcase
    unique case (fi)
      2'd0:    return l44;
      2'd1:    return l48;
      default: return l32;
    endcase
  endfunction

endpackage

// ===== rtl/core/mp3_frame_scanner_core.sv =====
// MP3 frame scanner: takes a file one byte per transaction, skips ID3v1/ID3v2
// tags at frame boundaries, checks each MPEG-1 Layer III header and reports
// every frame with its offset, length, rate and channel count. Bytes that
// yield no result are accepted back to back, so the scanner streams one byte
// per clock through tags, headers and frame bodies. A byte that yields a
// result keeps in_ready low from its transaction until the result transaction
// completes, or until the second one completes when a frame header ends on
// the last byte of a file and two results follow; out_ready low prolongs this.
// Frame lengths come from a constant table indexed by bitrate and rate codes.
// Depends on msc_pkg, msc_ctrl and msc_datapath.
module mp3_frame_scanner_core
  import msc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_frame_offset,
  output logic [10:0] out_frame_length,
  output logic [31:0] out_header_word,
  output logic [15:0] out_sample_rate,
  output logic [1:0]  out_channel_count,
  output logic        out_first_frame,
  output logic [31:0] out_frames_seen,
  output logic        out_last
);

  msc_cmd_t cmd;
  msc_sts_t sts;

  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_data_byte      (in_data_byte),
    .in_end_of_file    (in_end_of_file),
    .out_status        (out_status),
    .out_frame_offset  (out_frame_offset),
    .out_frame_length  (out_frame_length),
    .out_header_word   (out_header_word),
    .out_sample_rate   (out_sample_rate),
    .out_channel_count (out_channel_count),
    .out_first_frame   (out_first_frame),
    .out_frames_seen   (out_frames_seen),
    .out_last          (out_last)
  );

endmodule

// ===== rtl/core/msc_ctrl.sv =====
// Handshake controller of the MP3 frame scanner.
// Depends on msc_pkg; drives msc_datapath through msc_cmd_t.
module msc_ctrl
  import msc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  msc_sts_t   sts,
  output msc_cmd_t   cmd
);

  msc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SCAN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_eof = 1'b0;
    unique case (state_r)
      ST_SCAN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step = 1'b1;
          if (sts.res_any) begin
            state_nxt = sts.eof_next ? ST_RES_THEN_EOF : ST_RES;
          end
        end
      end
      ST_RES: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_RES_THEN_EOF: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.load_eof = 1'b1;
          state_nxt    = ST_RES;
        end
      end
      default: state_nxt = ST_SCAN;
    endcase
  end

endmodule

// ===== rtl/core/msc_datapath.sv =====
// Scan state, header decode and result register of the MP3 frame scanner.
// Depends on msc_pkg; commanded by msc_ctrl.
module msc_datapath
  import msc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  msc_cmd_t     cmd,
  output msc_sts_t     sts,
  input  logic [7:0]   in_data_byte,
  input  logic         in_end_of_file,
  output logic [1:0]   out_status,
  output logic [31:0]  out_frame_offset,
  output logic [10:0]  out_frame_length,
  output logic [31:0]  out_header_word,
  output logic [15:0]  out_sample_rate,
  output logic [1:0]   out_channel_count,
  output logic         out_first_frame,
  output logic [31:0]  out_frames_seen,
  output logic         out_last
);

  msc_mode_t              mode_r, mode_nxt;
  logic [27:0]            skip_r, skip_nxt;
  logic [31:0]            hdr_r, hdr_nxt;
  logic [3:0]             bbs_r, bbs_nxt;
  logic [27:0]            tacc_r, tacc_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [31:0]            fcnt_r, fcnt_nxt;
  logic                   tchk_r, tchk_nxt;

  // first result of the byte
  logic [1:0]  r_status;
  logic [31:0] r_offset;
  logic [10:0] r_length;
  logic [31:0] r_header;
  logic [15:0] r_rate;
  logic [1:0]  r_chan;
  logic        r_first;
  logic        r_last;

  logic [31:0]            hsh;
  logic [3:0]             bbs_inc;
  logic                   hdr_ok;
  logic [3:0]             br;
  logic [1:0]             fi;
  logic [10:0]            flen;
  logic [OFFSET_BITS-1:0] start;
  logic                   found, stopped_now;

  always_comb begin
    mode_nxt    = mode_r;
    skip_nxt    = skip_r;
    hdr_nxt     = hdr_r;
    bbs_nxt     = bbs_r;
    tacc_nxt    = tacc_r;
    off_nxt     = off_r + OFFSET_BITS'(1);
    fcnt_nxt    = fcnt_r;
    tchk_nxt    = tchk_r;
    found       = 1'b0;
    stopped_now = 1'b0;

    hsh     = {hdr_r[23:0], in_data_byte};
    bbs_inc = bbs_r + 4'd1;
    br      = hsh[15:12];
    fi      = hsh[11:10];
    hdr_ok  = (hsh[31:21] == 11'h7FF) && (hsh[20:19] == 2'd3) && (hsh[18:17] == 2'd1)
              && (br != 4'd0) && (br != 4'd15) && (fi != 2'd3);
    flen    = frame_len(br, fi) + {10'd0, hsh[9]};
    start   = off_r - OFFSET_BITS'(3);

    unique case (mode_r)
      MODE_BOUNDARY: begin
        hdr_nxt = hsh;
        bbs_nxt = bbs_inc;
        if (!tchk_r && bbs_inc == 4'd3) begin
          if (hsh[23:0] == MARK_ID3V1) begin
            skip_nxt = ID3V1_REST;
            tchk_nxt = 1'b1;
            bbs_nxt  = 4'd0;
            hdr_nxt  = 32'd0;
            mode_nxt = MODE_SKIP;
          end else if (hsh[23:0] == MARK_ID3V2) begin
            tacc_nxt = 28'd0;
            mode_nxt = MODE_ID3;
          end
        end else if (bbs_inc >= 4'd4) begin
          bbs_nxt = 4'd0;
          hdr_nxt = 32'd0;
          if (hdr_ok) begin
            found    = 1'b1;
            if (fcnt_r != '1) begin
              fcnt_nxt = fcnt_r + 32'd1;
            end
            skip_nxt = 28'(flen) - 28'd4;
            tchk_nxt = 1'b0;
            mode_nxt = MODE_SKIP;
          end else begin
            stopped_now = 1'b1;
            mode_nxt    = MODE_STOPPED;
          end
        end
      end
      MODE_ID3: begin
        bbs_nxt = bbs_inc;
        if (bbs_inc >= ID3V2_SIZE_START) begin
          tacc_nxt = {tacc_r[20:0], in_data_byte[6:0]};
        end
        if (bbs_inc >= ID3V2_HDR_BYTES) begin
          skip_nxt = tacc_nxt;
          tchk_nxt = 1'b1;
          bbs_nxt  = 4'd0;
          hdr_nxt  = 32'd0;
          mode_nxt = (tacc_nxt == 28'd0) ? MODE_BOUNDARY : MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (skip_r != 28'd0) begin
          skip_nxt = skip_r - 28'd1;
        end
        if (skip_nxt == 28'd0) begin
          bbs_nxt  = 4'd0;
          hdr_nxt  = 32'd0;
          mode_nxt = MODE_BOUNDARY;
        end
      end
      MODE_STOPPED: begin
        off_nxt = off_r;
      end
      default: mode_nxt = MODE_BOUNDARY;
    endcase

    // first result: frame, rejected header, or end of file
    r_status = STAT_EOF;
    r_offset = 32'd0;
    r_length = 11'd0;
    r_header = 32'd0;
    r_rate   = 16'd0;
    r_chan   = 2'd0;
    r_first  = 1'b0;
    r_last   = 1'b1;
    if (found) begin
      r_status = STAT_FRAME;
      r_offset = 32'(start);
      r_length = flen;
      r_header = hsh;
      r_rate   = rate_hz(fi);
      r_chan   = (hsh[7:6] == 2'd3) ? 2'd1 : 2'd2;
      r_first  = (fcnt_r == 32'd0);
      r_last   = 1'b0;
    end else if (stopped_now) begin
      r_status = STAT_INVALID;
      r_offset = 32'(start);
      r_header = hsh;
    end

    sts.res_any  = found || stopped_now || (in_end_of_file && mode_r != MODE_STOPPED);
    sts.eof_next = found && in_end_of_file;

    if (in_end_of_file) begin
      mode_nxt = MODE_BOUNDARY;
      skip_nxt = 28'd0;
      hdr_nxt  = 32'd0;
      bbs_nxt  = 4'd0;
      tacc_nxt = 28'd0;
      off_nxt  = '0;
      fcnt_nxt = 32'd0;
      tchk_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BOUNDARY;
      skip_r <= 28'd0;
      hdr_r  <= 32'd0;
      bbs_r  <= 4'd0;
      tacc_r <= 28'd0;
      off_r  <= '0;
      fcnt_r <= 32'd0;
      tchk_r <= 1'b0;
    end else if (cmd.step) begin
      mode_r <= mode_nxt;
      skip_r <= skip_nxt;
      hdr_r  <= hdr_nxt;
      bbs_r  <= bbs_nxt;
      tacc_r <= tacc_nxt;
      off_r  <= off_nxt;
      fcnt_r <= fcnt_nxt;
      tchk_r <= tchk_nxt;
    end
  end

  // result register; frames_seen is shared by a frame and its trailing eof result
  always_ff @(posedge clk) begin
    if (cmd.step && sts.res_any) begin
      out_status        <= r_status;
      out_frame_offset  <= r_offset;
      out_frame_length  <= r_length;
      out_header_word   <= r_header;
      out_sample_rate   <= r_rate;
      out_channel_count <= r_chan;
      out_first_frame   <= r_first;
      out_frames_seen   <= found ? ((fcnt_r != '1) ? fcnt_r + 32'd1 : fcnt_r) : fcnt_r;
      out_last          <= r_last;
    end else if (cmd.load_eof) begin
      out_status        <= STAT_EOF;
      out_frame_offset  <= 32'd0;
      out_frame_length  <= 11'd0;
      out_header_word   <= 32'd0;
      out_sample_rate   <= 16'd0;
      out_channel_count <= 2'd0;
      out_first_frame   <= 1'b0;
      out_last          <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/msc_checker.sv =====
// Port-level checker for mp3_frame_scanner_core, bound to the top level.
// Depends on msc_pkg.
module msc_checker
  import msc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_frame_offset,
  input logic [15:0] out_sample_rate,
  input logic [31:0] out_frames_seen,
  input logic        out_last
);

  // a pending result transaction holds its offset and status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_offset) && $stable(out_status))
    else $error("result changed while stalled");

  // input is not taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // only frame results may be followed by more results of the same file
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == STAT_FRAME)
    else $error("non-frame result without last");

  // a reported frame has a rate and has been counted
  a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FRAME |-> out_sample_rate != 16'd0 && out_frames_seen != 32'd0)
    else $error("frame result with empty fields");

endmodule

bind mp3_frame_scanner_core msc_checker u_msc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_frame_offset (out_frame_offset),
  .out_sample_rate  (out_sample_rate),
  .out_frames_seen  (out_frames_seen),
  .out_last         (out_last)
);
